// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that an expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
// Check that a condition is followed by a consequence in the next cycle.
`define ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- hw/rtl/iolhm_pkg.sv -----
// Types, constants and codes of the IO latency histogram monitor.
package iolhm_pkg;

  localparam int TAG_COUNT   = 64;
  localparam int BIN_COUNT   = 25;
  localparam int CLASS_COUNT = 10;

  localparam int SLOT_COUNT = CLASS_COUNT * 2;
  localparam int HIST_DEPTH = SLOT_COUNT * BIN_COUNT;
  localparam int TAG_AW     = $clog2(TAG_COUNT);
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int HIST_AW    = $clog2(HIST_DEPTH);

  localparam int DIV_DIVISOR = 1000;
  localparam int LAT_W       = 64;
  localparam int DIV_CMP_W   = LAT_W + $clog2(DIV_DIVISOR);

  typedef enum logic [1:0] {
    ACT_START    = 2'd0,
    ACT_COMPLETE = 2'd1,
    ACT_READ     = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_RECORDED = 3'd0,
    ST_FILTERED = 3'd1,
    ST_UNKNOWN  = 3'd2,
    ST_COUNTED  = 3'd3,
    ST_DROPPED  = 3'd4,
    ST_READ     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_EVAL,
    S_DIV,
    S_HRD,
    S_HWR
  } state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  tag;
    logic [31:0] group_id;
    logic        class_known;
    logic [3:0]  io_class;
    logic        is_write;
    logic [31:0] length;
    logic [63:0] now_ns;
    logic [4:0]  bin_select;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  bucket;
    logic [31:0] bin_count;
    logic [63:0] byte_total;
  } out_item_t;

  typedef struct packed {
    logic latch;
    logic clr_step;
    logic fetch;
    logic at_eval;
    logic eval_emit;
    logic cmp_begin;
    logic hist_rd;
    logic hwr_emit;
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    cmp_ok;
    logic    clr_done;
    logic    div_done;
    logic    out_free;
  } sts_t;

endpackage

// ----- hw/rtl/iolhm_ctrl.sv -----
// Controller state machine of the IO latency histogram monitor.
module iolhm_ctrl import iolhm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (sts.clr_done) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_FETCH;
      S_FETCH: state_nxt = S_EVAL;
      S_EVAL: begin
        if (sts.action == ACT_COMPLETE && sts.cmp_ok) begin
          state_nxt = S_DIV;
        end else if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV:   if (sts.div_done) state_nxt = S_HRD;
      S_HRD:   state_nxt = S_HWR;
      S_HWR:   if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    case (state_r)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        in_stall  = 1'b0;
        cmd.latch = in_valid;
      end
      S_FETCH: cmd.fetch = 1'b1;
      S_EVAL: begin
        cmd.at_eval = 1'b1;
        if (sts.action == ACT_COMPLETE && sts.cmp_ok) begin
          cmd.cmp_begin = 1'b1;
        end else begin
          cmd.eval_emit = sts.out_free;
        end
      end
      S_HRD:   cmd.hist_rd = 1'b1;
      S_HWR:   cmd.hwr_emit = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- hw/rtl/iolhm_div.sv -----
// Latency bucket unit: bit length of the dividend over 1000, at least 1, by constant compares.
module iolhm_div import iolhm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  logic [63:0] dividend,
  output logic        done,
  output logic [6:0]  bucket
);

  logic [63:0]          dvd_r;
  logic                 busy_r;
  logic                 done_r;
  logic [6:0]           bkt_r;
  logic [6:0]           bkt_nxt;
  logic [DIV_CMP_W-1:0] dvd_ext;

  assign dvd_ext = DIV_CMP_W'(dvd_r);
  assign done    = done_r;
  assign bucket  = bkt_r;

  // the quotient reaches 2^k exactly when the dividend reaches 1000 * 2^k
  always_comb begin
    bkt_nxt = 7'd1;
    for (int k = 0; k < LAT_W; k++) begin
      if (dvd_ext >= (DIV_CMP_W'(DIV_DIVISOR) << k)) bkt_nxt = 7'(k + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= load;
      done_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) dvd_r <= dividend;
    if (busy_r) bkt_r <= bkt_nxt;
  end

endmodule

// ----- hw/rtl/iolhm_dp.sv -----
// Datapath: tag store, histogram memory, byte totals and result register.
module iolhm_dp import iolhm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  in_item_t    in_data,
  input  logic        cfg_valid,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  cmd_t        cmd,
  output sts_t        sts
);

  in_item_t           item_r;
  logic [31:0]        target_r;
  logic [TAG_COUNT-1:0] tag_valid_r;
  logic [3:0]         tag_cls_mem [TAG_COUNT];
  logic [63:0]        tag_time_mem [TAG_COUNT];
  logic [3:0]         tcls_q_r;
  logic [63:0]        ttime_q_r;
  logic [31:0]        hist_mem [HIST_DEPTH];
  logic [31:0]        hist_q_r;
  logic [63:0]        byte_tot_r [SLOT_COUNT];
  logic [HIST_AW-1:0] clr_addr_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [HIST_AW-1:0] hidx_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic [TAG_AW-1:0]  tag_idx;
  logic               tag_in;
  logic               start_ok;
  logic [3:0]         cls_rec;
  logic [3:0]         cmp_cls;
  logic [SLOT_W-1:0]  cmp_slot;
  logic               rd_cls_ok;
  logic               rd_sel_ok;
  logic [SLOT_W-1:0]  rd_slot;
  logic [HIST_AW-1:0] rd_hidx;
  logic [SLOT_W-1:0]  tot_idx;
  logic [63:0]        tot_q;
  logic               bkt_ok;
  logic [6:0]         bucket;
  logic               div_done;
  logic [31:0]        cnt_inc;
  logic               hist_we;
  logic [HIST_AW-1:0] hist_wa;
  logic [31:0]        hist_wd;
  logic               hist_re;
  logic [HIST_AW-1:0] hist_ra;
  logic               emit;
  out_item_t          res;

  assign tag_idx  = item_r.tag[TAG_AW-1:0];
  assign tag_in   = 32'(item_r.tag) < TAG_COUNT;
  assign start_ok = (item_r.group_id == target_r) && tag_in;
  assign cls_rec  = (item_r.class_known && 32'(item_r.io_class) < CLASS_COUNT) ?
                    item_r.io_class : 4'd0;
  assign cmp_cls  = (32'(tcls_q_r) < CLASS_COUNT) ? tcls_q_r : 4'd0;
  assign cmp_slot = SLOT_W'({cmp_cls, item_r.is_write});

  assign rd_cls_ok = 32'(item_r.io_class) < CLASS_COUNT;
  assign rd_sel_ok = 32'(item_r.bin_select) < BIN_COUNT;
  assign rd_slot   = rd_cls_ok ? SLOT_W'({item_r.io_class, item_r.is_write}) : '0;
  assign rd_hidx   = (rd_cls_ok && rd_sel_ok) ?
                     HIST_AW'(32'(rd_slot) * BIN_COUNT + 32'(item_r.bin_select)) : '0;

  // one read port on the byte totals
  assign tot_idx = !cmd.at_eval ? slot_r :
                   (item_r.action == ACT_READ) ? rd_slot : cmp_slot;
  assign tot_q   = byte_tot_r[tot_idx];

  assign bkt_ok  = 32'(bucket) < BIN_COUNT;
  assign cnt_inc = (hist_q_r == 32'hFFFF_FFFF) ? hist_q_r : hist_q_r + 32'd1;

  assign sts.action   = action_t'(item_r.action);
  assign sts.cmp_ok   = tag_in && tag_valid_r[tag_idx];
  assign sts.clr_done = cmd.clr_step && (clr_addr_r == HIST_AW'(HIST_DEPTH - 1));
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || !out_stall;

  iolhm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (cmd.cmp_begin),
    .dividend (item_r.now_ns - ttime_q_r),
    .done     (div_done),
    .bucket   (bucket)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) item_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_valid) begin
      target_r <= cfg_data;
    end
  end

  // tag store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_valid_r <= '0;
    end else if (cmd.eval_emit && item_r.action == ACT_START && start_ok) begin
      tag_valid_r[tag_idx] <= 1'b1;
    end else if (cmd.cmp_begin) begin
      tag_valid_r[tag_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval_emit && item_r.action == ACT_START && start_ok) begin
      tag_cls_mem[tag_idx]  <= cls_rec;
      tag_time_mem[tag_idx] <= item_r.now_ns;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      tcls_q_r  <= tag_cls_mem[tag_idx];
      ttime_q_r <= tag_time_mem[tag_idx];
    end
  end

  // byte totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) byte_tot_r[i] <= '0;
    end else if (cmd.cmp_begin) begin
      byte_tot_r[cmp_slot] <= tot_q + 64'(item_r.length);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp_begin) slot_r <= cmp_slot;
    if (cmd.hist_rd) hidx_r <= hist_ra;
  end

  // histogram memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step && !sts.clr_done) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  assign hist_we = cmd.clr_step || (cmd.hwr_emit && bkt_ok);
  assign hist_wa = cmd.clr_step ? clr_addr_r : hidx_r;
  assign hist_wd = cmd.clr_step ? 32'd0 : cnt_inc;
  assign hist_re = cmd.fetch || cmd.hist_rd;
  assign hist_ra = cmd.fetch ? rd_hidx :
                   bkt_ok ? HIST_AW'(32'(slot_r) * BIN_COUNT + 32'(bucket)) : '0;

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_wa] <= hist_wd;
  end

  always_ff @(posedge clk) begin
    if (hist_re) hist_q_r <= hist_mem[hist_ra];
  end

  // result
  always_comb begin
    res = '0;
    if (cmd.hwr_emit) begin
      res.bucket     = bucket;
      res.byte_total = tot_q;
      if (bkt_ok) begin
        res.status    = ST_COUNTED;
        res.bin_count = cnt_inc;
      end else begin
        res.status = ST_DROPPED;
      end
    end else begin
      case (action_t'(item_r.action))
        ACT_START:    res.status = start_ok ? ST_RECORDED : ST_FILTERED;
        ACT_COMPLETE: res.status = ST_UNKNOWN;
        ACT_READ: begin
          res.status = ST_READ;
          if (rd_cls_ok) begin
            res.byte_total = tot_q;
            res.bin_count  = rd_sel_ok ? hist_q_r : 32'd0;
          end
        end
        default:      res.status = ST_FILTERED;
      endcase
    end
  end

  assign emit = cmd.eval_emit || cmd.hwr_emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hw/rtl/io_latency_histogram_monitor.sv -----
// Top level of the IO latency histogram monitor.
//
//  channel | ports                        | handshake
//  --------+------------------------------+---------------------------
//  input   | in_valid in_stall in_data    | transfer: valid && !stall
//  result  | out_valid out_stall out_data | transfer: valid && !stall
//  config  | cfg_valid cfg_ready cfg_data | transfer: valid && ready
//
// Starts, reads and unknown completions go through the fetch and evaluate states.
// Counted or dropped completions add the bucket compare, histogram read and write.
// After reset a clearing pass sweeps the 500 histogram bins, one per cycle;
// in_stall stays high meanwhile, configuration transfers are taken as ever.
// One item is in work at a time; a held result stalls only the finishing step.
module io_latency_histogram_monitor import iolhm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  iolhm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  iolhm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- hw/rtl/iolhm_chk.sv -----
// Port-level checker of the IO latency histogram monitor and its bind.
`include "assert_macros.svh"
module iolhm_chk import iolhm_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input out_item_t   out_data
);

  logic plain_st;

  // results that carry no count and no total
  assign plain_st = (out_data.status == ST_RECORDED) || (out_data.status == ST_FILTERED) ||
                    (out_data.status == ST_UNKNOWN);

  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data))
  `ASSERT_NEXT(a_one_in_work, in_valid && !in_stall, in_stall)
  `ASSERT_ALWAYS(a_plain_zero, !(out_valid && plain_st) || (out_data.bin_count == 32'd0 && out_data.byte_total == 64'd0))

endmodule

bind io_latency_histogram_monitor iolhm_chk u_chk (.*);
